[sv/brf_pkg.sv]
// Shared types and constants for the byte ring FIFO with overflow discard.
// No dependencies; brf_step, the top level and the checker use this package.
package brf_pkg;

    // Ring size in bytes and cap on the bytes returned by one read request.
    localparam int DEPTH    = 1024;
    localparam int MAX_READ = 64;

    // Fixed field widths of the transfers.
    localparam int LEN_W    = 10;
    localparam int BYTE_W   = 8;
    localparam int UNREAD_W = 11;

    // Widths derived from the ring size.
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = PTR_W + 1;
    localparam int RD_W   = $clog2(MAX_READ + 1);
    localparam int WIDE_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] HALF_C  = CNT_W'(DEPTH / 2);

    // Request type codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] push_byte;
        logic              chunk_start;
        logic [LEN_W-1:0]  length;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                last;
        logic                empty_res;
        logic [UNREAD_W-1:0] unread_after;
    } res_t;

    // Operands of the shared pointer/count step unit.
    typedef struct packed {
        logic [PTR_W-1:0] ptr;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] amount;
        logic             sub;
    } step_req_t;

    typedef struct packed {
        logic [PTR_W-1:0] ptr;
        logic [CNT_W-1:0] cnt;
    } step_rsp_t;

endpackage

[sv/brf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies; width and depth are set per instance.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/brf_step.sv]
// Shared step unit: advance a ring pointer modulo DEPTH and add to or
// subtract from the unread count. Depends on brf_pkg.
module brf_step (
    input  brf_pkg::step_req_t req,
    output brf_pkg::step_rsp_t rsp
);

    logic [brf_pkg::CNT_W-1:0] sum;
    logic [brf_pkg::CNT_W-1:0] wrapped;

    // Pointer is below DEPTH and amount at most DEPTH: one compare and subtract wraps it.
    assign sum     = brf_pkg::CNT_W'(req.ptr) + req.amount;
    assign wrapped = (sum >= brf_pkg::DEPTH_C) ? (sum - brf_pkg::DEPTH_C) : sum;
    assign rsp.ptr = wrapped[brf_pkg::PTR_W-1:0];
    assign rsp.cnt = req.sub ? (req.cnt - req.amount) : (req.cnt + req.amount);

endmodule

[sv/byte_ring_fifo_drop_half.sv]
// Top level of the byte ring FIFO with overflow discard: sequencer, ring RAM,
// shared step unit and result register. Depends on brf_pkg, brf_ram, brf_step.
//
// Usage:
//   Request channel (req_valid / req_stall / req_item): each transfer is either a
//   push of one byte or a read request for up to req_item.length bytes, capped at
//   MAX_READ and at the unread count.
//   Result channel (res_valid / res_stall / res_item): a read returns one transfer
//   per byte, oldest first, with last set on the final one. A read that finds no
//   byte returns one transfer with empty_res and last set and out_byte zero.
//   Pushes return nothing.
//   A chunk-start push whose length would overflow the ring first drops the oldest
//   DEPTH/2 unread bytes (all of them if fewer remain). A push into a full ring
//   overwrites the oldest byte.
// Sequencing:
//   The block works on one request at a time; req_stall is high while busy.
//   A push passes through ST_PUSH_WR, preceded by ST_PUSH_DROP when it discards
//   and followed by ST_PUSH_FULL when the ring is full. A read handles each byte in
//   ST_RD_ADDR (RAM read and pointer step), then ST_RD_DATA (load the result
//   register). All pointer and count updates share a single step unit.
// Reset clears pointers, count and result valid; ring contents are not cleared.
// A stalled result holds in the result register and the read sequence waits.
module byte_ring_fifo_drop_half (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  brf_pkg::req_t req_item,
    output logic          res_valid,
    input  logic          res_stall,
    output brf_pkg::res_t res_item
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_PUSH_DROP = 3'd1;
    localparam logic [2:0] ST_PUSH_WR   = 3'd2;
    localparam logic [2:0] ST_PUSH_FULL = 3'd3;
    localparam logic [2:0] ST_RD_ADDR   = 3'd4;
    localparam logic [2:0] ST_RD_DATA   = 3'd5;
    localparam logic [2:0] ST_RD_EMPTY  = 3'd6;

    logic [2:0]                 state_reg,  state_next;
    logic [brf_pkg::PTR_W-1:0]  rp_reg,     rp_next;
    logic [brf_pkg::PTR_W-1:0]  wp_reg,     wp_next;
    logic [brf_pkg::CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [brf_pkg::RD_W-1:0]   remain_reg, remain_next;
    logic [brf_pkg::BYTE_W-1:0] byte_reg,   byte_next;
    logic                       out_valid_reg, out_valid_next;
    brf_pkg::res_t              out_reg,    out_next;

    logic                       req_xfer;
    logic                       out_free;
    logic [brf_pkg::WIDE_W-1:0] len_w;
    logic [brf_pkg::WIDE_W-1:0] cnt_w;
    logic [brf_pkg::WIDE_W-1:0] cap_len;
    logic [brf_pkg::WIDE_W-1:0] rd_cnt;
    logic                       overflow;
    logic [brf_pkg::CNT_W-1:0]  drop_amt;

    brf_pkg::step_req_t         step_req;
    brf_pkg::step_rsp_t         step_rsp;

    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [brf_pkg::BYTE_W-1:0] ram_q;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !res_stall;

    // Decode the request while idle: overflow test for pushes, byte count for reads.
    assign len_w    = brf_pkg::WIDE_W'(req_item.length);
    assign cnt_w    = brf_pkg::WIDE_W'(cnt_reg);
    assign overflow = req_item.chunk_start && ((cnt_w + len_w) > brf_pkg::WIDE_W'(brf_pkg::DEPTH));
    assign cap_len  = (len_w > brf_pkg::WIDE_W'(brf_pkg::MAX_READ))
                    ? brf_pkg::WIDE_W'(brf_pkg::MAX_READ) : len_w;
    assign rd_cnt   = (cap_len > cnt_w) ? cnt_w : cap_len;
    assign drop_amt = (cnt_reg > brf_pkg::HALF_C) ? brf_pkg::HALF_C : cnt_reg;

    // Operand select for the shared step unit.
    always_comb
    begin
        step_req.ptr    = rp_reg;
        step_req.cnt    = cnt_reg;
        step_req.amount = '0;
        step_req.sub    = 1'b1;
        case (state_reg)
            ST_PUSH_DROP:
            begin
                step_req.amount = drop_amt;
            end
            ST_PUSH_WR:
            begin
                step_req.ptr    = wp_reg;
                step_req.amount = brf_pkg::CNT_W'(1);
                step_req.sub    = 1'b0;
            end
            ST_PUSH_FULL, ST_RD_ADDR:
            begin
                step_req.amount = brf_pkg::CNT_W'(1);
            end
            default:
            begin
                step_req.amount = '0;
            end
        endcase
    end

    brf_step u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    assign ram_wr_en = (state_reg == ST_PUSH_WR);
    assign ram_rd_en = (state_reg == ST_RD_ADDR);

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (brf_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (byte_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (rp_reg),
        .rd_data (ram_q)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        remain_next    = remain_reg;
        byte_next      = byte_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && res_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    byte_next   = req_item.push_byte;
                    remain_next = brf_pkg::RD_W'(rd_cnt);
                    if (req_item.req_type == brf_pkg::REQ_PUSH)
                    begin
                        state_next = overflow ? ST_PUSH_DROP : ST_PUSH_WR;
                    end
                    else if (rd_cnt == '0)
                    begin
                        state_next = ST_RD_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_RD_ADDR;
                    end
                end
            end
            ST_PUSH_DROP:
            begin
                // Drop the oldest unread bytes before the chunk lands.
                rp_next    = step_rsp.ptr;
                cnt_next   = step_rsp.cnt;
                state_next = ST_PUSH_WR;
            end
            ST_PUSH_WR:
            begin
                wp_next = step_rsp.ptr;
                if (cnt_reg == brf_pkg::DEPTH_C)
                begin
                    state_next = ST_PUSH_FULL;
                end
                else
                begin
                    cnt_next   = step_rsp.cnt;
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH_FULL:
            begin
                // Ring was full: the new byte replaced the oldest, advance past it.
                rp_next    = step_rsp.ptr;
                state_next = ST_IDLE;
            end
            ST_RD_ADDR:
            begin
                rp_next     = step_rsp.ptr;
                cnt_next    = step_rsp.cnt;
                remain_next = remain_reg - brf_pkg::RD_W'(1);
                state_next  = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_byte     = ram_q;
                    out_next.last         = (remain_reg == '0);
                    out_next.empty_res    = 1'b0;
                    out_next.unread_after = brf_pkg::UNREAD_W'(cnt_reg);
                    state_next            = (remain_reg == '0) ? ST_IDLE : ST_RD_ADDR;
                end
            end
            ST_RD_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_byte     = '0;
                    out_next.last         = 1'b1;
                    out_next.empty_res    = 1'b1;
                    out_next.unread_after = brf_pkg::UNREAD_W'(cnt_reg);
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        out_reg  <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

endmodule

[sv/brf_checker.sv]
// Port-level checker for byte_ring_fifo_drop_half, attached by bind.
// Depends on brf_pkg for the transfer types.
module brf_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input brf_pkg::req_t req_item,
    input logic          res_valid,
    input logic          res_stall,
    input brf_pkg::res_t res_item
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result changed or dropped");

    // An empty result ends its read and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.empty_res |-> res_item.last && (res_item.out_byte == '0))
        else $error("empty result without last or with a byte");

    // Every request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken on back-to-back cycles");

    // A read in progress holds off new requests until its last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.last |-> req_stall)
        else $error("request channel opened in the middle of a read");

endmodule

bind byte_ring_fifo_drop_half brf_checker u_brf_checker (.*);
